@@ sv/pgm_pkg.sv @@
// ---------------------------------------------------------------------------
// pgm_pkg
// Shared types and constants of the Prewitt gradient magnitude/phase block.
// ---------------------------------------------------------------------------
package pgm_pkg;

  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int GRAD_W    = 11;
  localparam int MAG_W     = 15;
  localparam int ORI_W     = 12;

  // square root chain: radicand below 2^29, one result bit per cell
  localparam int SQ_W     = 30;
  localparam int SQ_STEPS = 15;

  // angle chain: operands carry 20 fraction bits, angle in 2^-16 degree
  localparam int CX_W         = 33;
  localparam int Z_W          = 25;
  localparam int TH_W         = 24;
  localparam int CORDIC_STEPS = 21;
  localparam int CORDIC_FRAC  = 20;

  localparam logic signed [Z_W-1:0] ANG_90  = 25'sd5898240;
  localparam logic [TH_W-1:0]       ANG_180 = 24'd11796480;
  localparam logic [TH_W:0]         ORI_RND = 25'd2048;

  localparam logic signed [Z_W-1:0] CORDIC_ANGLE [CORDIC_STEPS] = '{
    25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945, 25'sd234379,
    25'sd117304, 25'sd58666, 25'sd29335, 25'sd14668, 25'sd7334,
    25'sd3667, 25'sd1833, 25'sd917, 25'sd458, 25'sd229,
    25'sd115, 25'sd57, 25'sd29, 25'sd14, 25'sd7, 25'sd4
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ANG_CORDIC,
    ANG_FLAT,
    ANG_VERT
  } ang_mode_t;

  typedef struct packed {
    logic                     vld;
    logic                     last;
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
  } grad_t;

  typedef struct packed {
    logic      vld;
    logic      last;
    logic      neg;
    ang_mode_t mode;
  } side_t;

  typedef struct packed {
    logic signed [CX_W-1:0] cx;
    logic signed [CX_W-1:0] cy;
    logic signed [Z_W-1:0]  z;
  } cordic_t;

  typedef struct packed {
    logic [SQ_W-1:0] n;
    logic [SQ_W-1:0] r;
  } sqrt_t;

endpackage

@@ sv/pgm_in_if.sv @@
// ---------------------------------------------------------------------------
// pgm_in_if
// Pixel input channel: valid/ready with request type and grey level.
// ---------------------------------------------------------------------------
interface pgm_in_if import pgm_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] pixel;

  modport source (output valid, output req_type, output pixel, input ready);
  modport sink (input valid, input req_type, input pixel, output ready);
endinterface

@@ sv/pgm_out_if.sv @@
// ---------------------------------------------------------------------------
// pgm_out_if
// Result channel: valid/ready with magnitude, orientation and frame end.
// ---------------------------------------------------------------------------
interface pgm_out_if import pgm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [MAG_W-1:0] magnitude;
  logic [ORI_W-1:0] orientation;
  logic             last;

  modport source (output valid, output magnitude, output orientation, output last,
                  input ready);
  modport sink (input valid, input magnitude, input orientation, input last,
                output ready);
endinterface

@@ sv/pgm_window.sv @@
// ---------------------------------------------------------------------------
// pgm_window
// Raster counters, two-row line store and 3x3 window; produces gx and gy.
// ---------------------------------------------------------------------------
module pgm_window import pgm_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               acc,
  input  logic                               restart,
  input  logic                               req_type,
  input  logic [7:0]                         pixel,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]     w_eff,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]    h_eff,
  output grad_t                              grad
);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH+1);
  localparam int RW = $clog2(MAX_HEIGHT+2);

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [RW-1:0] h_ext, h_p1;
  logic          col0, in_frame, top_ok, mid_ok, res_ok, is_last;
  logic [7:0]    pv;

  logic          s0_vld_r;
  logic [CW-1:0] s0_addr_r;
  logic [7:0]    s0_pv_r;
  logic          s0_top_ok_r, s0_mid_ok_r, s0_col0_r, s0_res_r, s0_last_r;

  // entry holds {row above above, row above} for one column
  logic [15:0] mem [MAX_WIDTH];
  logic [15:0] mem_q_r, fwd_data_r, rd, wdata;
  logic        fwd_r, hit;
  logic [7:0]  top, mid;

  logic [7:0] win_r [9];
  logic [7:0] win_nxt [9];
  logic [7:0] o [9];
  logic [9:0] s_right, s_left, s_bot, s_top;
  logic signed [GRAD_W-1:0] gx, gy;

  always_comb begin
    h_ext    = RW'(h_eff);
    h_p1     = h_ext + 1'b1;
    col0     = (col_r == '0);
    in_frame = (row_r < h_ext);
    top_ok   = (row_r >= RW'(2)) && (row_r <= h_p1);
    mid_ok   = (row_r >= RW'(1)) && (row_r <= h_ext);
    res_ok   = col0 ? top_ok : mid_ok;
    is_last  = col0 && (row_r == h_p1);
    pv       = (!req_type && in_frame) ? pixel : 8'd0;
    if (is_last) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if ((WW'(col_r) + 1'b1) == w_eff) begin
      col_nxt = '0;
      row_nxt = row_r + 1'b1;
    end else begin
      col_nxt = col_r + 1'b1;
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      col_r <= '0;
      row_r <= '0;
    end else if (acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s0_addr_r   <= col_r;
      s0_pv_r     <= pv;
      s0_top_ok_r <= top_ok;
      s0_mid_ok_r <= mid_ok;
      s0_col0_r   <= col0;
      s0_res_r    <= res_ok;
      s0_last_r   <= is_last;
    end
  end

  // same-column write and read in one edge happens for one-pixel rows and at a frame wrap
  assign hit   = en && s0_vld_r && (s0_addr_r == col_r);
  assign rd    = fwd_r ? fwd_data_r : mem_q_r;
  assign wdata = {rd[7:0], s0_pv_r};
  assign top   = s0_top_ok_r ? rd[15:8] : 8'd0;
  assign mid   = s0_mid_ok_r ? rd[7:0] : 8'd0;

  always_ff @(posedge clk) begin
    if (en && s0_vld_r) begin
      mem[s0_addr_r] <= wdata;
    end
    if (acc) begin
      mem_q_r    <= mem[col_r];
      fwd_r      <= hit;
      fwd_data_r <= wdata;
    end
  end

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      o[i] = win_r[i+3];
    end
    o[6] = s0_col0_r ? 8'd0 : top;
    o[7] = s0_col0_r ? 8'd0 : mid;
    o[8] = s0_col0_r ? 8'd0 : s0_pv_r;
    for (int i = 0; i < 6; i++) begin
      win_nxt[i] = s0_col0_r ? 8'd0 : o[i];
    end
    win_nxt[6] = top;
    win_nxt[7] = mid;
    win_nxt[8] = s0_pv_r;
    s_right = {2'b0, o[6]} + {2'b0, o[7]} + {2'b0, o[8]};
    s_left  = {2'b0, o[0]} + {2'b0, o[1]} + {2'b0, o[2]};
    s_bot   = {2'b0, o[2]} + {2'b0, o[5]} + {2'b0, o[8]};
    s_top   = {2'b0, o[0]} + {2'b0, o[3]} + {2'b0, o[6]};
    gx = $signed({1'b0, s_right}) - $signed({1'b0, s_left});
    gy = $signed({1'b0, s_bot}) - $signed({1'b0, s_top});
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= 8'd0;
      end
    end else if (en && s0_vld_r) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= s0_last_r ? 8'd0 : win_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grad.vld <= 1'b0;
    end else if (en) begin
      grad.vld <= s0_vld_r && s0_res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      grad.last <= s0_last_r;
      grad.gx   <= gx;
      grad.gy   <= gy;
    end
  end

endmodule

@@ sv/pgm_sqrt_cell.sv @@
// ---------------------------------------------------------------------------
// pgm_sqrt_cell
// One digit of the restoring square root; hands remainder and root onward.
// ---------------------------------------------------------------------------
module pgm_sqrt_cell import pgm_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic  clk,
  input  logic  en,
  input  sqrt_t d,
  output sqrt_t q
);
  localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * STEP);

  logic [SQ_W:0] trial;
  sqrt_t         q_nxt;

  always_comb begin
    trial = {1'b0, d.r} + {1'b0, BIT};
    if ({1'b0, d.n} >= trial) begin
      q_nxt.n = d.n - trial[SQ_W-1:0];
      q_nxt.r = (d.r >> 1) + BIT;
    end else begin
      q_nxt.n = d.n;
      q_nxt.r = d.r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_nxt;
    end
  end

endmodule

@@ sv/pgm_cordic_cell.sv @@
// ---------------------------------------------------------------------------
// pgm_cordic_cell
// One vectoring rotation of the angle chain, with its sideband.
// ---------------------------------------------------------------------------
module pgm_cordic_cell import pgm_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  cordic_t d,
  input  side_t   ds,
  output cordic_t q,
  output side_t   qs
);
  logic signed [CX_W-1:0] dx, dy;
  cordic_t                q_nxt;

  always_comb begin
    dx = d.cy >>> STEP;
    dy = d.cx >>> STEP;
    if (!d.cy[CX_W-1]) begin
      q_nxt.cx = d.cx + dx;
      q_nxt.cy = d.cy - dy;
      q_nxt.z  = d.z + CORDIC_ANGLE[STEP];
    end else begin
      q_nxt.cx = d.cx - dx;
      q_nxt.cy = d.cy + dy;
      q_nxt.z  = d.z - CORDIC_ANGLE[STEP];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qs.vld <= 1'b0;
    end else if (en) begin
      qs.vld <= ds.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q       <= q_nxt;
      qs.last <= ds.last;
      qs.neg  <= ds.neg;
      qs.mode <= ds.mode;
    end
  end

endmodule

@@ sv/prewitt_gradient_magnitude_phase.sv @@
// ---------------------------------------------------------------------------
// prewitt_gradient_magnitude_phase
// Prewitt 3x3 gradient magnitude and unsigned orientation on a pixel stream.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch  : one transaction per raster position; req_type 0 is a pixel,
//            req_type 1 a flush position. Send frame_width+1 flush
//            transactions after a frame to drain its last row.
//   out_ch : magnitude (4 fraction bits), orientation in 1/16 degree
//            (0..2880) and last on the final pixel of the frame.
//   cfg    : write frame_width (index 0) or frame_height (index 1) while
//            idle; any such write restarts the frame.
// Throughput: one transaction per cycle while out_ch does not stall. The result
//   for a pixel belongs to the input transaction frame_width+1 positions later
//   and passes the window stage loaded at the edge that accepts that transaction,
//   the gradient register, one square/setup stage, 21 angle cells (the 15 root
//   cells run beside them) and the output register before it is valid on out_ch.
// Reset: counters, window and config (640 x 480) return to defaults; the
//   line store holds no reset, rows not yet seen are masked to zero.
// Stall: while a result waits on out_ch, the whole pipe holds and in_ch
//   ready drops in the same cycle.
// ---------------------------------------------------------------------------
module prewitt_gradient_magnitude_phase import pgm_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,
  pgm_in_if.sink               in_ch,
  pgm_out_if.source            out_ch,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);
  localparam int WW  = $clog2(MAX_WIDTH+1);
  localparam int HW  = $clog2(MAX_HEIGHT+1);
  localparam int DLY = CORDIC_STEPS - SQ_STEPS;

  logic [CFG_W-1:0] cfg_width_r, cfg_height_r;
  logic [WW-1:0]    w_eff;
  logic [HW-1:0]    h_eff;
  logic             restart, en, acc;
  grad_t            grad;

  logic signed [GRAD_W-1:0]   xs, ys;
  logic [GRAD_W-1:0]          ax, ay;
  logic signed [2*GRAD_W-1:0] px, py;
  logic [SQ_W-1:0]            msum;
  sqrt_t                      sq_init;
  cordic_t                    cor_init;
  side_t                      side_init;

  sqrt_t   sq  [SQ_STEPS+1];
  cordic_t cor [CORDIC_STEPS+1];
  side_t   sd  [CORDIC_STEPS+1];

  logic [MAG_W-1:0] mag_q;
  logic [MAG_W-1:0] mag_dly_r [DLY];

  logic [TH_W-1:0] phi, th;
  logic [TH_W:0]   th_rnd;

  logic             out_valid_r;
  logic [MAG_W-1:0] out_mag_r;
  logic [ORI_W-1:0] out_ori_r;
  logic             out_last_r;

  // configuration
  assign restart = cfg_wr_en &&
                   (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= 11'd640;
      cfg_height_r <= 11'd480;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  cfg_width_r  <= cfg_wdata;
        CFG_FRAME_HEIGHT: cfg_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_width_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(cfg_width_r) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg_width_r);
    end
    if (cfg_height_r == '0) begin
      h_eff = HW'(1);
    end else if (32'(cfg_height_r) > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(cfg_height_r);
    end
  end

  assign en          = !(out_valid_r && !out_ch.ready);
  assign acc         = in_ch.valid && en;
  assign in_ch.ready = en;

  pgm_window #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .acc      (acc),
    .restart  (restart),
    .req_type (in_ch.req_type),
    .pixel    (in_ch.pixel),
    .w_eff    (w_eff),
    .h_eff    (h_eff),
    .grad     (grad)
  );

  // squares for the root, fold into the upper half plane for the angle
  always_comb begin
    px   = grad.gx * grad.gx;
    py   = grad.gy * grad.gy;
    msum = SQ_W'($unsigned(px)) + SQ_W'($unsigned(py));
    sq_init.n = msum << 8;
    sq_init.r = '0;

    xs = grad.gy[GRAD_W-1] ? -grad.gx : grad.gx;
    ys = grad.gy[GRAD_W-1] ? -grad.gy : grad.gy;
    ax = xs[GRAD_W-1] ? $unsigned(-xs) : $unsigned(xs);
    ay = $unsigned(ys);
    cor_init.cx = CX_W'({ax, {CORDIC_FRAC{1'b0}}});
    cor_init.cy = CX_W'({ay, {CORDIC_FRAC{1'b0}}});
    cor_init.z  = '0;

    side_init.vld  = grad.vld;
    side_init.last = grad.last;
    side_init.neg  = xs[GRAD_W-1];
    if (ys == '0) begin
      side_init.mode = ANG_FLAT;
    end else if (ax == '0) begin
      side_init.mode = ANG_VERT;
    end else begin
      side_init.mode = ANG_CORDIC;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sd[0].vld <= 1'b0;
    end else if (en) begin
      sd[0].vld <= side_init.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq[0]      <= sq_init;
      cor[0]     <= cor_init;
      sd[0].last <= side_init.last;
      sd[0].neg  <= side_init.neg;
      sd[0].mode <= side_init.mode;
    end
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    pgm_sqrt_cell #(
      .STEP (SQ_STEPS - 1 - k)
    ) u_cell (
      .clk (clk),
      .en  (en),
      .d   (sq[k]),
      .q   (sq[k+1])
    );
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    pgm_cordic_cell #(
      .STEP (k)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d     (cor[k]),
      .ds    (sd[k]),
      .q     (cor[k+1]),
      .qs    (sd[k+1])
    );
  end

  // round to nearest, then wait for the angle chain
  assign mag_q = sq[SQ_STEPS].r[MAG_W-1:0] +
                 MAG_W'(sq[SQ_STEPS].n > sq[SQ_STEPS].r);

  always_ff @(posedge clk) begin
    if (en) begin
      mag_dly_r[0] <= mag_q;
      for (int i = 1; i < DLY; i++) begin
        mag_dly_r[i] <= mag_dly_r[i-1];
      end
    end
  end

  always_comb begin
    case (sd[CORDIC_STEPS].mode)
      ANG_CORDIC: begin
        if (cor[CORDIC_STEPS].z < 0) begin
          phi = '0;
        end else if (cor[CORDIC_STEPS].z > ANG_90) begin
          phi = TH_W'(ANG_90);
        end else begin
          phi = TH_W'(cor[CORDIC_STEPS].z);
        end
      end
      ANG_VERT: phi = TH_W'(ANG_90);
      default:  phi = '0;
    endcase
    th     = sd[CORDIC_STEPS].neg ? (ANG_180 - phi) : phi;
    th_rnd = {1'b0, th} + ORI_RND;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sd[CORDIC_STEPS].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_mag_r  <= mag_dly_r[DLY-1];
      out_ori_r  <= ORI_W'(th_rnd >> 12);
      out_last_r <= sd[CORDIC_STEPS].last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.magnitude   = out_mag_r;
  assign out_ch.orientation = out_ori_r;
  assign out_ch.last        = out_last_r;

  // checks
  a_ori_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.orientation <= 12'd2880)
    else $error("orientation above 180 degrees");

  a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.magnitude <= 15'd17310)
    else $error("magnitude above largest gradient");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("input taken while output stalled");

  a_stall_holds_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.last)))
    else $error("pending result changed during stall");

endmodule

@@ bench/prewitt_gradient_magnitude_phase_tb.sv @@
// ---------------------------------------------------------------------------
// prewitt_gradient_magnitude_phase_tb
// Streams frames of many sizes and contents through the gradient block,
// predicts every magnitude/orientation/last result in the bench and checks
// each result transaction in order, under random and forced stalls.
// ---------------------------------------------------------------------------
module prewitt_gradient_magnitude_phase_tb;
  import pgm_pkg::*;

  localparam int LINE_MAX     = 1024;
  localparam int ROWS_MAX     = 1024;
  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT  = 3000;
  localparam int RANDOM_ITEMS = 300;

  localparam bit REQ_PIXEL = 1'b0;
  localparam bit REQ_FLUSH = 1'b1;

  typedef enum int {
    FILL_RANDOM, FILL_FLAT, FILL_ZERO, FILL_EXTREME, FILL_RAMP, FILL_NOISY
  } fill_t;

  typedef struct {
    logic [MAG_W-1:0] magnitude;
    logic [ORI_W-1:0] orientation;
    logic             last;
  } grad_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  pgm_in_if  in_if ();
  pgm_out_if out_if ();

  prewitt_gradient_magnitude_phase u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  initial begin
    in_if.valid    = 1'b0;
    in_if.req_type = 1'b0;
    in_if.pixel    = '0;
    out_if.ready   = 1'b0;
  end

  // gradient predictor state
  logic [10:0] frame_w = 11'd640;
  logic [10:0] frame_h = 11'd480;
  logic [7:0]  line_mem [2*LINE_MAX];
  logic [7:0]  win [9];
  int          col_pos = 0;
  int          row_pos = 0;

  grad_result_t pending_results[$];
  int  error_count = 0;
  int  items_sent = 0;
  int  src_idle_pct = 0;
  int  snk_idle_pct = 0;
  int  hold_cycles = 0;
  int  quiet_cycles = 0;

  localparam longint ATAN_STEP [21] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4
  };

  function automatic int unsigned root_of(int unsigned n);
    int unsigned r, b;
    r = 0;
    b = 32'h4000_0000;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [MAG_W-1:0] grad_magnitude(int gx, int gy);
    int unsigned n, q;
    n = (gx * gx + gy * gy) * 256;
    q = root_of(n);
    if (n - q * q > q) q++;
    return q[MAG_W-1:0];
  endfunction

  function automatic logic [ORI_W-1:0] grad_angle(int gx, int gy);
    longint x, y, ax, phi, th, k, cx, cy, z, dx, dy;
    bit neg;
    x = gx;
    y = gy;
    if (y < 0) begin
      x = -x;
      y = -y;
    end
    if (x == 0 && y == 0) return '0;
    neg = x < 0;
    ax = neg ? -x : x;
    if (y == 0) begin
      phi = 0;
    end else if (ax == 0) begin
      phi = 90 * 65536;
    end else begin
      cx = ax * 1048576;
      cy = y * 1048576;
      z = 0;
      for (int i = 0; i < 21; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (cy >= 0) begin
          cx += dx; cy -= dy; z += ATAN_STEP[i];
        end else begin
          cx -= dx; cy += dy; z -= ATAN_STEP[i];
        end
      end
      if (z < 0) z = 0;
      if (z > 90 * 65536) z = 90 * 65536;
      phi = z;
    end
    th = neg ? 180 * 65536 - phi : phi;
    k = (th + 2048) >>> 12;
    if (k > 2880) k = 2880;
    return k[ORI_W-1:0];
  endfunction

  function automatic void restart_frame();
    foreach (win[i]) win[i] = '0;
    col_pos = 0;
    row_pos = 0;
  endfunction

  function automatic void predict_position(logic req, logic [7:0] pix);
    int w, h, r, c, cr, cc, gx, gy;
    logic [7:0] pv, top, mid;
    logic [7:0] o [9];
    bit ok, fin;
    grad_result_t res;
    w = frame_w; h = frame_h;
    if (w < 1) w = 1;
    if (w > LINE_MAX) w = LINE_MAX;
    if (h < 1) h = 1;
    if (h > ROWS_MAX) h = ROWS_MAX;
    r = row_pos; c = col_pos;
    if (c >= w) c = 0;
    pv  = (req == REQ_PIXEL && r < h) ? pix : 8'd0;
    top = (r >= 2 && r - 2 < h) ? line_mem[c] : 8'd0;
    mid = (r >= 1 && r - 1 < h) ? line_mem[LINE_MAX + c] : 8'd0;
    line_mem[c] = line_mem[LINE_MAX + c];
    line_mem[LINE_MAX + c] = pv;
    for (int i = 0; i < 6; i++) o[i] = win[i + 3];
    if (c == 0) begin
      o[6] = 0; o[7] = 0; o[8] = 0;
      ok = (r >= 2 && r - 2 < h);
      cr = r - 2; cc = w - 1;
      for (int i = 0; i < 6; i++) win[i] = '0;
      win[6] = top; win[7] = mid; win[8] = pv;
    end else begin
      o[6] = top; o[7] = mid; o[8] = pv;
      ok = (r >= 1 && r - 1 < h);
      cr = r - 1; cc = c - 1;
      for (int i = 0; i < 9; i++) win[i] = o[i];
    end
    fin = 1'b0;
    if (ok) begin
      gx = 0; gy = 0;
      for (int k = 0; k < 3; k++) begin
        gx += int'(o[6 + k]) - int'(o[k]);
        gy += int'(o[3 * k + 2]) - int'(o[3 * k]);
      end
      fin = (cr == h - 1 && cc == w - 1);
      res.magnitude   = grad_magnitude(gx, gy);
      res.orientation = grad_angle(gx, gy);
      res.last        = fin;
      pending_results.push_back(res);
    end
    if (fin) begin
      restart_frame();
    end else begin
      c++;
      if (c >= w) begin
        c = 0;
        r++;
      end
      col_pos = c;
      row_pos = r;
    end
  endfunction

  // result side: stalls and checking
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_if.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  always @(posedge clk) begin
    grad_result_t exp_res;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no expectation waiting");
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_if.magnitude !== exp_res.magnitude) begin
          $error("magnitude: expected %0d, got %0d", exp_res.magnitude, out_if.magnitude);
          error_count++;
        end
        if (out_if.orientation !== exp_res.orientation) begin
          $error("orientation: expected %0d, got %0d", exp_res.orientation,
                 out_if.orientation);
          error_count++;
        end
        if (out_if.last !== exp_res.last) begin
          $error("last: expected %0d, got %0d", exp_res.last, out_if.last);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_position(logic req, logic [7:0] pix);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.req_type <= req;
    in_if.pixel    <= pix;
    do @(posedge clk); while (!in_if.ready);
    predict_position(req, pix);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
    wait_drained();
    // positions with no result may still be inside the pipe
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_FRAME_WIDTH) frame_w = val;
    else frame_h = val;
    restart_frame();
  endtask

  task automatic set_size(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
  endtask

  function automatic logic [7:0] fill_pixel(fill_t fill, int x, int y);
    case (fill)
      FILL_FLAT:    return 8'd255;
      FILL_ZERO:    return 8'd0;
      FILL_EXTREME: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
      FILL_RAMP:    return 8'((x * 37 + y * 91) & 8'hff);
      default:      return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one frame then its flush positions; noisy fill swaps kinds now and then
  task automatic send_frame(int w, int h, fill_t fill);
    logic req;
    for (int y = 0; y < h; y++) begin
      for (int x = 0; x < w; x++) begin
        req = (fill == FILL_NOISY && $urandom_range(0, 9) == 0) ? REQ_FLUSH : REQ_PIXEL;
        send_position(req, fill_pixel(fill, x, y));
      end
    end
    for (int i = 0; i <= w; i++) begin
      req = (fill == FILL_NOISY && $urandom_range(0, 9) == 0) ? REQ_PIXEL : REQ_FLUSH;
      send_position(req, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_directed();
    set_size(11'd3, 11'd3);
    send_frame(3, 3, FILL_FLAT);
    send_frame(3, 3, FILL_EXTREME);
    send_frame(3, 3, FILL_ZERO);
    // zero registers behave as one
    set_size(11'd0, 11'd0);
    send_position(REQ_PIXEL, 8'd255);
    send_position(REQ_FLUSH, 8'd0);
    send_position(REQ_FLUSH, 8'd255);
    set_size(11'd2, 11'd2);
    send_position(REQ_FLUSH, 8'd200);
    send_position(REQ_PIXEL, 8'd255);
    send_position(REQ_PIXEL, 8'd0);
    send_position(REQ_PIXEL, 8'd128);
    send_frame(2, 2, FILL_RAMP);
  endtask

  // oversized registers act as the maximum; the row wraps after 1024 positions
  task automatic test_extreme_sizes();
    set_size(11'd2047, 11'd2047);
    for (int i = 0; i < LINE_MAX + 4; i++) begin
      send_position(REQ_PIXEL, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_backpressure();
    set_size(11'd20, 11'd4);
    src_idle_pct = 0;
    hold_cycles = 300;
    for (int i = 0; i < 60; i++) send_position(REQ_PIXEL, 8'($urandom_range(0, 255)));
    // pause until every result so far has come
    wait_drained();
    for (int i = 0; i < 20; i++) send_position(REQ_PIXEL, 8'($urandom_range(0, 255)));
    for (int i = 0; i < 21; i++) send_position(REQ_FLUSH, 8'd0);
  endtask

  task automatic test_random_frames();
    int w, h, target;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      case ((3 * (RANDOM_ITEMS - (target - items_sent))) / RANDOM_ITEMS)
        0: begin src_idle_pct = 30; snk_idle_pct = 66; end
        1: begin src_idle_pct = 66; snk_idle_pct = 30; end
        default: begin src_idle_pct = 0; snk_idle_pct = 0; end
      endcase
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 6);
      set_size(w[CFG_W-1:0], h[CFG_W-1:0]);
      repeat ($urandom_range(1, 3)) begin
        case ($urandom_range(0, 9))
          0:       send_frame(w, h, FILL_NOISY);
          1:       send_frame(w, h, FILL_EXTREME);
          2:       send_frame(w, h, FILL_RAMP);
          3:       send_frame(w, h, FILL_FLAT);
          default: send_frame(w, h, FILL_RANDOM);
        endcase
      end
    end
    src_idle_pct = 0;
    snk_idle_pct = 0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    restart_frame();
    src_idle_pct = 30;
    snk_idle_pct = 66;
    test_directed();
    test_backpressure();
    src_idle_pct = 66;
    snk_idle_pct = 30;
    test_extreme_sizes();
    test_random_frames();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
